// File: src/htpl_pkg.sv
`timescale 1ns / 1ps

package htpl_pkg;

    // opcodes carried in the input tuser
    typedef enum logic [1:0] {
        OP_WRITE_SLOT   = 2'd0,
        OP_WRITE_EXISTS = 2'd1,
        OP_LOOKUP       = 2'd2,
        OP_UNUSED       = 2'd3
    } t_opcode;

    // register indexes, byte address is 4 * index
    typedef enum logic [1:0] {
        REG_TABLE_SIZE     = 2'd0,
        REG_BLOCK_COUNT    = 2'd1,
        REG_EMPTY_MARKER   = 2'd2,
        REG_DELETED_MARKER = 2'd3
    } t_reg_index;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_RD,
        S_CHK,
        S_EX,
        S_DONE
    } t_state;

    localparam int CFG_COUNT_W = 11;
    localparam int HASH_W      = 32;
    localparam int SLOT_W      = 10;
    localparam int ENTRY_W     = 3 * HASH_W;

    // remainder unit retires two dividend bits per cycle
    localparam int MOD_STEPS = HASH_W / 2;
    localparam int MOD_CNT_W = $clog2(MOD_STEPS);

    // input tdata layout
    localparam int IN_SLOT_LSB  = 0;
    localparam int IN_NA_LSB    = IN_SLOT_LSB + SLOT_W;
    localparam int IN_NB_LSB    = IN_NA_LSB + HASH_W;
    localparam int IN_BLK_LSB   = IN_NB_LSB + HASH_W;
    localparam int IN_EX_BIT    = IN_BLK_LSB + HASH_W;
    localparam int IN_KIH_LSB   = IN_EX_BIT + 1;
    localparam int IN_KA_LSB    = IN_KIH_LSB + HASH_W;
    localparam int IN_KB_LSB    = IN_KA_LSB + HASH_W;
    localparam int IN_USED_W    = IN_KB_LSB + HASH_W;
    localparam int IN_TDATA_W   = ((IN_USED_W + 7) / 8) * 8;

    // output tdata layout
    localparam int OUT_SLOT_LSB = 0;
    localparam int OUT_BLK_LSB  = OUT_SLOT_LSB + SLOT_W;
    localparam int OUT_FE_BIT   = OUT_BLK_LSB + SLOT_W;
    localparam int OUT_USED_W   = OUT_FE_BIT + 1;
    localparam int OUT_TDATA_W  = ((OUT_USED_W + 7) / 8) * 8;

endpackage

// File: src/htpl_ram.sv
`timescale 1ns / 1ps

module htpl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/hash_table_probe_lookup_top.sv
`timescale 1ns / 1ps

// Linear-probing hash table lookup.
// Input stream (s_axis): tuser carries the opcode, tdata the slot, entry and
// key fields. A slot write or an exists-flag write gives no output item; a
// lookup gives exactly one output item (m_axis).
// Lookup steps after the accepting edge: the start-slot remainder (the
// compare-subtract unit retires two hash bits a cycle), then for each probed
// slot a slot RAM registered read and a compare, on a hit an exists-flag RAM
// read, and last the load of the output register. A table size of zero goes
// straight to the output load. The next input item can be taken in the cycle
// after the output register loads.
// tready is high only while the sequencer is idle.
// The output register holds a finished item while m_axis stalls; a following
// write item is still taken, a following lookup waits in its last step until
// the register frees.
// Reset idles the sequencer, drops the output item and resets the config.
// Table RAMs are not cleared; entries must be written before they are probed.
// Config: APB, register i at byte address 4*i, written in the access phase.

module hash_table_probe_lookup_top #(
    parameter int SLOT_DEPTH  = 1024,
    parameter int BLOCK_DEPTH = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,

    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // slot, entry_name_a, entry_name_b, entry_block, exists_bit,
    // key_index_hash, key_name_a, key_name_b (low to high), zero fill
    input  logic [htpl_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // opcode
    input  logic [1:0]                       i_s_axis_tuser,

    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // hit_slot, hit_block, file_exists (low to high), zero fill
    output logic [htpl_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    // found
    output logic                             o_m_axis_tuser,

    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [3:0]                       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    localparam int SW  = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;   // slot index
    localparam int BW  = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1; // block index
    localparam int SZW = $clog2(SLOT_DEPTH + 1);                      // table size
    localparam logic [31:0] SLOT_DEPTH_W  = 32'(SLOT_DEPTH);
    localparam logic [31:0] BLOCK_DEPTH_W = 32'(BLOCK_DEPTH);
    localparam logic [htpl_pkg::MOD_CNT_W-1:0] MOD_LAST =
        htpl_pkg::MOD_CNT_W'(htpl_pkg::MOD_STEPS - 1);

    // ---------------- configuration ----------------
    logic [htpl_pkg::CFG_COUNT_W-1:0] r_table_size;
    logic [htpl_pkg::CFG_COUNT_W-1:0] r_block_count;
    logic [31:0]                      r_empty_marker;
    logic [31:0]                      r_deleted_marker;
    logic                             w_cfg_we;

    assign pready   = 1'b1;
    assign w_cfg_we = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size     <= '0;
            r_block_count    <= '0;
            r_empty_marker   <= 32'hFFFF_FFFF;
            r_deleted_marker <= 32'hFFFF_FFFE;
        end else if (w_cfg_we) begin
            case (htpl_pkg::t_reg_index'(paddr[3:2]))
                htpl_pkg::REG_TABLE_SIZE: begin
                    r_table_size <= pwdata[htpl_pkg::CFG_COUNT_W-1:0];
                end
                htpl_pkg::REG_BLOCK_COUNT: begin
                    r_block_count <= pwdata[htpl_pkg::CFG_COUNT_W-1:0];
                end
                htpl_pkg::REG_EMPTY_MARKER: begin
                    r_empty_marker <= pwdata;
                end
                htpl_pkg::REG_DELETED_MARKER: begin
                    r_deleted_marker <= pwdata;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (htpl_pkg::t_reg_index'(paddr[3:2]))
            htpl_pkg::REG_TABLE_SIZE:     prdata = 32'(r_table_size);
            htpl_pkg::REG_BLOCK_COUNT:    prdata = 32'(r_block_count);
            htpl_pkg::REG_EMPTY_MARKER:   prdata = r_empty_marker;
            htpl_pkg::REG_DELETED_MARKER: prdata = r_deleted_marker;
            default:                      prdata = '0;
        endcase
    end

    // effective sizes, saturated at the RAM depths
    logic [31:0]    w_ts32;
    logic [31:0]    w_bc32;
    logic [SZW-1:0] w_size;
    logic [31:0]    w_blocks;

    assign w_ts32   = 32'(r_table_size);
    assign w_bc32   = 32'(r_block_count);
    assign w_size   = (w_ts32 < SLOT_DEPTH_W) ? w_ts32[SZW-1:0] : SLOT_DEPTH_W[SZW-1:0];
    assign w_blocks = (w_bc32 < BLOCK_DEPTH_W) ? w_bc32 : BLOCK_DEPTH_W;

    // ---------------- input fields ----------------
    htpl_pkg::t_opcode   w_op;
    logic [31:0]         w_slot32;
    logic [htpl_pkg::ENTRY_W-1:0] w_entry;
    logic                w_in_accept;

    assign w_op     = htpl_pkg::t_opcode'(i_s_axis_tuser);
    assign w_slot32 = 32'(i_s_axis_tdata[htpl_pkg::IN_SLOT_LSB +: htpl_pkg::SLOT_W]);
    // entry word: name_a low, name_b middle, block high
    assign w_entry  = i_s_axis_tdata[htpl_pkg::IN_NA_LSB +: htpl_pkg::ENTRY_W];
    assign w_in_accept = i_s_axis_tvalid & o_s_axis_tready;

    // ---------------- sequencer state ----------------
    htpl_pkg::t_state r_state, n_state;

    logic [31:0]                     r_div;
    logic [SZW-1:0]                  r_rem;
    logic [htpl_pkg::MOD_CNT_W-1:0]  r_cnt;
    logic [31:0]                     r_ka, r_kb;
    logic [SW-1:0]                   r_start, r_idx;
    logic                            r_res_found, r_res_fe;
    logic [htpl_pkg::SLOT_W-1:0]     r_res_slot, r_res_block;

    logic                            r_out_valid, r_out_found, r_out_fe;
    logic [htpl_pkg::SLOT_W-1:0]     r_out_slot, r_out_block;

    // RAMs
    logic [htpl_pkg::ENTRY_W-1:0] w_slot_rdata;
    logic                         w_ex_rdata;
    logic                         w_slot_we, w_ex_we;

    htpl_ram #(
        .WIDTH(htpl_pkg::ENTRY_W),
        .DEPTH(SLOT_DEPTH)
    ) u_slot_ram (
        .i_clk  (i_clk),
        .i_we   (w_slot_we),
        .i_waddr(w_slot32[SW-1:0]),
        .i_wdata(w_entry),
        .i_raddr(r_idx),
        .o_rdata(w_slot_rdata)
    );

    // remainder unit: two restoring compare-subtract steps
    logic [SZW:0]   w_t1, w_t2;
    logic [SZW-1:0] w_m1, w_m2;

    always_comb begin
        w_t1 = {r_rem, r_div[31]};
        w_m1 = (w_t1 >= {1'b0, w_size}) ? SZW'(w_t1 - {1'b0, w_size}) : w_t1[SZW-1:0];
        w_t2 = {w_m1, r_div[30]};
        w_m2 = (w_t2 >= {1'b0, w_size}) ? SZW'(w_t2 - {1'b0, w_size}) : w_t2[SZW-1:0];
    end

    // probe compare on the registered slot read
    logic [31:0] w_e_na, w_e_nb, w_e_blk;
    logic        w_is_empty, w_is_match, w_blk_ok, w_wrap;
    logic [SZW:0] w_idx_inc;
    logic [SW-1:0] w_idx_next;

    assign w_e_na  = w_slot_rdata[31:0];
    assign w_e_nb  = w_slot_rdata[63:32];
    assign w_e_blk = w_slot_rdata[95:64];

    assign w_is_empty = (w_e_blk == r_empty_marker);
    assign w_is_match = (w_e_blk != r_deleted_marker) && (w_e_na == r_ka) && (w_e_nb == r_kb);
    assign w_blk_ok   = (w_e_blk < w_blocks);
    assign w_idx_inc  = (SZW + 1)'(r_idx) + 1'b1;
    assign w_idx_next = (w_idx_inc >= {1'b0, w_size}) ? '0 : w_idx_inc[SW-1:0];
    assign w_wrap     = (w_idx_next == r_start);

    htpl_ram #(
        .WIDTH(1),
        .DEPTH(BLOCK_DEPTH)
    ) u_exists_ram (
        .i_clk  (i_clk),
        .i_we   (w_ex_we),
        .i_waddr(w_slot32[BW-1:0]),
        .i_wdata(i_s_axis_tdata[htpl_pkg::IN_EX_BIT]),
        .i_raddr(w_e_blk[BW-1:0]),
        .o_rdata(w_ex_rdata)
    );

    logic w_out_free;
    assign w_out_free = !r_out_valid || i_m_axis_tready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            htpl_pkg::S_IDLE: begin
                if (w_in_accept && w_op == htpl_pkg::OP_LOOKUP) begin
                    n_state = (w_size == '0) ? htpl_pkg::S_DONE : htpl_pkg::S_MOD;
                end
            end
            htpl_pkg::S_MOD: begin
                if (r_cnt == MOD_LAST) begin
                    n_state = htpl_pkg::S_RD;
                end
            end
            htpl_pkg::S_RD: begin
                n_state = htpl_pkg::S_CHK;
            end
            htpl_pkg::S_CHK: begin
                if (w_is_empty) begin
                    n_state = htpl_pkg::S_DONE;
                end else if (w_is_match) begin
                    n_state = w_blk_ok ? htpl_pkg::S_EX : htpl_pkg::S_DONE;
                end else if (w_wrap) begin
                    n_state = htpl_pkg::S_DONE;
                end else begin
                    n_state = htpl_pkg::S_RD;
                end
            end
            htpl_pkg::S_EX: begin
                n_state = htpl_pkg::S_DONE;
            end
            htpl_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = htpl_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = htpl_pkg::S_IDLE;
            end
        endcase
    end

    // control outputs
    logic w_out_load, w_hit;

    always_comb begin
        o_s_axis_tready = 1'b0;
        w_slot_we       = 1'b0;
        w_ex_we         = 1'b0;
        w_out_load      = 1'b0;
        w_hit           = 1'b0;
        case (r_state)
            htpl_pkg::S_IDLE: begin
                o_s_axis_tready = 1'b1;
                w_slot_we = w_in_accept && (w_op == htpl_pkg::OP_WRITE_SLOT)
                            && (w_slot32 < SLOT_DEPTH_W);
                w_ex_we   = w_in_accept && (w_op == htpl_pkg::OP_WRITE_EXISTS)
                            && (w_slot32 < BLOCK_DEPTH_W);
            end
            htpl_pkg::S_CHK: begin
                w_hit = !w_is_empty && w_is_match && w_blk_ok;
            end
            htpl_pkg::S_DONE: begin
                w_out_load = w_out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= htpl_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            htpl_pkg::S_IDLE: begin
                r_div       <= i_s_axis_tdata[htpl_pkg::IN_KIH_LSB +: htpl_pkg::HASH_W];
                r_ka        <= i_s_axis_tdata[htpl_pkg::IN_KA_LSB +: htpl_pkg::HASH_W];
                r_kb        <= i_s_axis_tdata[htpl_pkg::IN_KB_LSB +: htpl_pkg::HASH_W];
                r_rem       <= '0;
                r_cnt       <= '0;
                r_res_found <= 1'b0;
                r_res_fe    <= 1'b0;
                r_res_slot  <= '0;
                r_res_block <= '0;
            end
            htpl_pkg::S_MOD: begin
                r_rem <= w_m2;
                r_div <= {r_div[29:0], 2'b00};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == MOD_LAST) begin
                    r_start <= w_m2[SW-1:0];
                    r_idx   <= w_m2[SW-1:0];
                end
            end
            htpl_pkg::S_CHK: begin
                if (w_hit) begin
                    r_res_found <= 1'b1;
                    r_res_slot  <= htpl_pkg::SLOT_W'(32'(r_idx));
                    r_res_block <= w_e_blk[htpl_pkg::SLOT_W-1:0];
                end else if (!w_is_empty && !w_is_match) begin
                    r_idx <= w_idx_next;
                end
            end
            htpl_pkg::S_EX: begin
                r_res_fe <= w_ex_rdata;
            end
            default: begin
            end
        endcase

        if (w_out_load) begin
            r_out_found <= r_res_found;
            r_out_slot  <= r_res_slot;
            r_out_block <= r_res_block;
            r_out_fe    <= r_res_fe;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_found;
    assign o_m_axis_tdata  = htpl_pkg::OUT_TDATA_W'({r_out_fe, r_out_block, r_out_slot});

endmodule
